// ===== hw/rtl/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Fan speed controller package
// Shared types, field widths, event codes and constants of the controller.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // Field widths.
  localparam int unsigned ModeW     = 3;
  localparam int unsigned TempW     = 12;
  localparam int unsigned DistW     = 12;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned LimitW    = 7;
  localparam int unsigned SpeedW    = 2;
  localparam int unsigned PeriodW   = 10;
  localparam int unsigned TickW     = 10;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_UPPER_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOWER_FLOOR = 2'd2;

  // Divider geometry: the quotient never exceeds 1000, so ten steps suffice.
  localparam int unsigned SqW       = 2 * TempW;
  localparam int unsigned QuoW      = PeriodW;
  localparam int unsigned DivCntW   = 4;
  localparam int unsigned DividendW = 25;
  localparam int unsigned ShiftW    = SqW + QuoW - 1;
  localparam logic [DividendW-1:0] BLINK_DIVIDEND = 25'd25600000;
  localparam logic [TempW-1:0]     BLINK_OFFSET   = 12'd160;

  // Motor PWM and proximity constants.
  localparam logic [TickW-1:0]  PWM_LAST   = 10'd10;
  localparam logic [TickW-1:0]  DUTY_HIGH  = 10'd6;
  localparam logic [TickW-1:0]  DUTY_LOW   = 10'd3;
  localparam logic [DistW-1:0]  NEAR_MIN   = 12'd1;
  localparam logic [DistW-1:0]  NEAR_MAX   = 12'd10;
  localparam logic [SpeedW-1:0] SPEED_OFF  = 2'd0;
  localparam logic [SpeedW-1:0] SPEED_LOW  = 2'd1;
  localparam logic [SpeedW-1:0] SPEED_MID  = 2'd2;
  localparam logic [SpeedW-1:0] SPEED_FULL = 2'd3;

  // Reset values.
  localparam logic [IntervalW-1:0] RST_INTERVAL    = 16'd500;
  localparam logic [LimitW-1:0]    RST_UPPER_LIMIT = 7'd80;
  localparam logic [LimitW-1:0]    RST_LOWER_FLOOR = 7'd1;
  localparam logic [LimitW-1:0]    RST_UPPER       = 7'd30;
  localparam logic [LimitW-1:0]    RST_LOWER       = 7'd20;
  localparam logic [PeriodW-1:0]   RST_PERIOD      = 10'd1000;

  // Event codes carried in the mode field.
  typedef enum logic [ModeW-1:0] {
    MODE_PWM    = 3'd0,
    MODE_SENSE  = 3'd1,
    MODE_UP     = 3'd2,
    MODE_DOWN   = 3'd3,
    MODE_SELECT = 3'd4,
    MODE_LONG   = 3'd5
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic start_div;
    logic div_step;
    logic apply;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_last;
  } stat_t;

  // One result item.
  typedef struct packed {
    logic               motor_on;
    logic               led_on;
    logic [SpeedW-1:0]  speed_level;
    logic               manual_on;
    logic [LimitW-1:0]  upper_threshold;
    logic [LimitW-1:0]  lower_threshold;
    logic               upper_selected;
    logic [PeriodW-1:0] blink_period;
  } res_t;

endpackage

// ===== hw/rtl/fsc_in_if.sv =====
// ----------------------------------------------------------------------------
// Fan controller event channel
// Valid/ready channel that carries one tick or key event per request.
// ----------------------------------------------------------------------------
interface fsc_in_if;
  import fsc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ModeW-1:0]        mode;
  logic signed [TempW-1:0] temperature;
  logic [DistW-1:0]        distance_mm;
  logic                    distance_error;

  modport source (output valid, mode, temperature, distance_mm, distance_error,
                  input ready);
  modport sink (input valid, mode, temperature, distance_mm, distance_error,
                output ready);
endinterface

// ===== hw/rtl/fsc_out_if.sv =====
// ----------------------------------------------------------------------------
// Fan controller status channel
// Valid/ready channel that carries the controller state after each event.
// ----------------------------------------------------------------------------
interface fsc_out_if;
  import fsc_pkg::*;

  logic               valid;
  logic               ready;
  logic               motor_on;
  logic               led_on;
  logic [SpeedW-1:0]  speed_level;
  logic               manual_on;
  logic [LimitW-1:0]  upper_threshold;
  logic [LimitW-1:0]  lower_threshold;
  logic               upper_selected;
  logic [PeriodW-1:0] blink_period;

  modport source (output valid, motor_on, led_on, speed_level, manual_on,
                  upper_threshold, lower_threshold, upper_selected, blink_period,
                  input ready);
  modport sink (input valid, motor_on, led_on, speed_level, manual_on,
                upper_threshold, lower_threshold, upper_selected, blink_period,
                output ready);
endinterface

// ===== hw/rtl/thermal_fan_speed_controller_core.sv =====
// ----------------------------------------------------------------------------
// Thermal fan speed controller
// Fan motor PWM, warning LED blinking, threshold keys and periodic
// temperature and distance evaluation.
//
//   channel  direction  contents
//   in_i     sink       event: mode, temperature, distance_mm, distance_error
//   out_o    source     state after the event, one result per request
//   cfg      write      sample_interval, upper_limit, lower_floor
//
// An event is captured in the idle state, then applied, then its result is
// loaded from the emit state once the output slot is free. An evaluation
// above the upper threshold runs the 10-step restoring divider for the blink
// period before the state update. A new request is taken while the previous
// result waits in the output register; a stalled output holds the next
// result back. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module thermal_fan_speed_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fsc_pkg::CfgDataW-1:0]  cfg_data_i,
  fsc_in_if.sink                        in_i,
  fsc_out_if.source                     out_o
);
  import fsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  in_ready;
  logic  out_valid;

  fsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fsc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mode_i           (in_i.mode),
    .temperature_i    (in_i.temperature),
    .distance_mm_i    (in_i.distance_mm),
    .distance_error_i (in_i.distance_error),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .res_o            (res)
  );

  // Channel connections.
  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid;
  assign out_o.motor_on        = res.motor_on;
  assign out_o.led_on          = res.led_on;
  assign out_o.speed_level     = res.speed_level;
  assign out_o.manual_on       = res.manual_on;
  assign out_o.upper_threshold = res.upper_threshold;
  assign out_o.lower_threshold = res.lower_threshold;
  assign out_o.upper_selected  = res.upper_selected;
  assign out_o.blink_period    = res.blink_period;

`ifndef SYNTHESIS
  // The sequencer issues at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.start_div, cmd.div_step, cmd.apply, cmd.load_out}))
    else $error("more than one datapath command in a cycle");

  // A divider start is followed by its first step.
  a_div_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_div |=> cmd.div_step)
    else $error("divider started without stepping");

  // The last divider step hands over to the state update.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step && stat.div_last) |=> cmd.apply)
    else $error("divider finished without applying the result");

  // A taken request makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

  // A shown blink period is never zero.
  a_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (res.blink_period != '0))
    else $error("zero blink period on the output");
`endif
endmodule

// ===== hw/rtl/fsc_div.sv =====
// ----------------------------------------------------------------------------
// Blink period divider
// Restoring divider, one quotient bit per cycle while stepped, for 25600000 / divisor.
// ----------------------------------------------------------------------------
module fsc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       step_i,
  input  logic [fsc_pkg::SqW-1:0]    divisor_i,
  output logic [fsc_pkg::QuoW-1:0]   quotient_o,
  output logic                       last_o
);
  import fsc_pkg::*;

  logic [SqW-1:0]       dsr_q;
  logic [DividendW-1:0] rem_q, rem_d;
  logic [QuoW-1:0]      quo_q, quo_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic [ShiftW-1:0]    trial;

  // Trial subtraction of the divisor aligned to the current quotient bit.
  always_comb begin
    trial = ShiftW'(dsr_q) << cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (step_i) begin
      if (ShiftW'(rem_q) >= trial) begin
        rem_d        = rem_q - trial[DividendW-1:0];
        quo_d[cnt_q] = 1'b1;
      end
      cnt_d = cnt_q - DivCntW'(1);
    end
  end

  // The divisor arrives straight from the squaring multiplier.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsr_q <= divisor_i;
      rem_q <= BLINK_DIVIDEND;
      quo_q <= '0;
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DivCntW'(QuoW - 1);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = (cnt_q == '0);
endmodule

// ===== hw/rtl/fsc_dp.sv =====
// ----------------------------------------------------------------------------
// Fan controller datapath
// Event registers, controller state, key and tick logic, blink divider and
// the result register.
// ----------------------------------------------------------------------------
module fsc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fsc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [fsc_pkg::ModeW-1:0]     mode_i,
  input  logic signed [fsc_pkg::TempW-1:0] temperature_i,
  input  logic [fsc_pkg::DistW-1:0]     distance_mm_i,
  input  logic                          distance_error_i,
  input  fsc_pkg::cmd_t                 cmd_i,
  output fsc_pkg::stat_t                stat_o,
  output fsc_pkg::res_t                 res_o
);
  import fsc_pkg::*;

  // Configuration registers.
  logic [IntervalW-1:0] interval_q;
  logic [LimitW-1:0]    upper_limit_q;
  logic [LimitW-1:0]    lower_floor_q;

  // Captured event.
  mode_e                   mode_q;
  logic signed [TempW-1:0] temp_q;
  logic [DistW-1:0]        dist_q;
  logic                    err_q;

  // Controller state.
  logic                 manual_q, manual_d;
  logic                 sel_upper_q, sel_upper_d;
  logic [SpeedW-1:0]    speed_q, speed_d;
  logic [LimitW-1:0]    upper_q, upper_d;
  logic [LimitW-1:0]    lower_q, lower_d;
  logic [IntervalW-1:0] sense_q, sense_d;
  logic [TickW-1:0]     tick_q, tick_d;
  logic                 blink_q, blink_d;
  logic [PeriodW-1:0]   period_q, period_d;
  logic                 motor_q, motor_d;
  logic                 led_q, led_d;

  res_t res_q;

  logic signed [TempW-1:0] up16, lo16;
  logic [TempW-1:0]        excess, blink_base;
  logic [SqW-1:0]          base_sq;
  logic                    hot, warm, near, evaluate;
  logic [QuoW-1:0]         quotient;
  logic                    div_last;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= RST_INTERVAL;
      upper_limit_q <= RST_UPPER_LIMIT;
      lower_floor_q <= RST_LOWER_FLOOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INTERVAL:    interval_q    <= cfg_data_i[IntervalW-1:0];
        CFG_UPPER_LIMIT: upper_limit_q <= cfg_data_i[LimitW-1:0];
        CFG_LOWER_FLOOR: lower_floor_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Event capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_e'(mode_i);
      temp_q <= temperature_i;
      dist_q <= distance_mm_i;
      err_q  <= distance_error_i;
    end
  end

  // Threshold comparisons in sixteenths of a degree.
  assign up16       = signed'({1'b0, upper_q, 4'b0000});
  assign lo16       = signed'({1'b0, lower_q, 4'b0000});
  assign hot        = (temp_q >= up16);
  assign warm       = (temp_q >= lo16);
  assign near       = err_q || ((dist_q >= NEAR_MIN) && (dist_q <= NEAR_MAX));
  assign evaluate   = (mode_q == MODE_SENSE) && !manual_q && (sense_q > interval_q);
  assign excess     = temp_q - up16;
  assign blink_base = excess + BLINK_OFFSET;
  assign base_sq    = SqW'(blink_base) * SqW'(blink_base);

  assign stat_o.need_div = evaluate && hot;
  assign stat_o.div_last = div_last;

  fsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .step_i     (cmd_i.div_step),
    .divisor_i  (base_sq),
    .quotient_o (quotient),
    .last_o     (div_last)
  );

  // Next state for the captured event.
  always_comb begin
    manual_d    = manual_q;
    sel_upper_d = sel_upper_q;
    speed_d     = speed_q;
    upper_d     = upper_q;
    lower_d     = lower_q;
    sense_d     = sense_q;
    tick_d      = tick_q;
    blink_d     = blink_q;
    period_d    = period_q;
    motor_d     = motor_q;
    led_d       = led_q;
    if (cmd_i.apply) begin
      unique case (mode_q)
        MODE_PWM: begin
          if (blink_q) begin
            // The shared counter times the LED toggles.
            if (tick_q >= period_q) begin
              led_d  = ~led_q;
              tick_d = '0;
            end else begin
              tick_d = tick_q + TickW'(1);
            end
          end else if (tick_q <= PWM_LAST) begin
            unique case (speed_q)
              SPEED_FULL: motor_d = 1'b1;
              SPEED_MID:  motor_d = (tick_q <= DUTY_HIGH);
              SPEED_LOW:  motor_d = (tick_q <= DUTY_LOW);
              default:    motor_d = 1'b0;
            endcase
            tick_d = tick_q + TickW'(1);
          end else begin
            tick_d = '0;
          end
        end
        MODE_SENSE: begin
          if (!manual_q) begin
            if (!evaluate) begin
              sense_d = sense_q + IntervalW'(1);
            end else begin
              sense_d = '0;
              if (hot) begin
                blink_d  = 1'b1;
                period_d = quotient;
              end else if (blink_q) begin
                led_d   = 1'b1;
                blink_d = 1'b0;
              end
              if (near) begin
                speed_d = SPEED_OFF;
                motor_d = 1'b0;
              end else if (hot) begin
                motor_d = 1'b1;
                speed_d = SPEED_FULL;
              end else if (warm) begin
                speed_d = SPEED_MID;
                led_d   = 1'b1;
              end else begin
                speed_d = SPEED_OFF;
                led_d   = 1'b1;
              end
            end
          end
        end
        MODE_UP: begin
          if (manual_q) begin
            if (speed_q != SPEED_FULL) speed_d = speed_q + SpeedW'(1);
          end else if (sel_upper_q) begin
            if (upper_q < upper_limit_q) upper_d = upper_q + LimitW'(1);
          end else if (lower_q < upper_q) begin
            lower_d = lower_q + LimitW'(1);
          end
        end
        MODE_DOWN: begin
          if (manual_q) begin
            if (speed_q != SPEED_OFF) speed_d = speed_q - SpeedW'(1);
          end else if (sel_upper_q) begin
            if (upper_q > lower_q) upper_d = upper_q - LimitW'(1);
          end else if (lower_q > lower_floor_q) begin
            lower_d = lower_q - LimitW'(1);
          end
        end
        MODE_SELECT: begin
          if (!manual_q) sel_upper_d = ~sel_upper_q;
        end
        MODE_LONG: begin
          manual_d = ~manual_q;
        end
        default: ;
      endcase
    end
  end

  // Controller state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q    <= 1'b0;
      sel_upper_q <= 1'b0;
      speed_q     <= SPEED_OFF;
      upper_q     <= RST_UPPER;
      lower_q     <= RST_LOWER;
      sense_q     <= '0;
      tick_q      <= '0;
      blink_q     <= 1'b0;
      period_q    <= RST_PERIOD;
      motor_q     <= 1'b0;
      led_q       <= 1'b1;
    end else begin
      manual_q    <= manual_d;
      sel_upper_q <= sel_upper_d;
      speed_q     <= speed_d;
      upper_q     <= upper_d;
      lower_q     <= lower_d;
      sense_q     <= sense_d;
      tick_q      <= tick_d;
      blink_q     <= blink_d;
      period_q    <= period_d;
      motor_q     <= motor_d;
      led_q       <= led_d;
    end
  end

  // Result register, loaded once the event has been applied.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q.motor_on        <= motor_q;
      res_q.led_on          <= led_q;
      res_q.speed_level     <= speed_q;
      res_q.manual_on       <= manual_q;
      res_q.upper_threshold <= upper_q;
      res_q.lower_threshold <= lower_q;
      res_q.upper_selected  <= sel_upper_q;
      res_q.blink_period    <= period_q;
    end
  end

  assign res_o = res_q;
endmodule

// ===== hw/rtl/fsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fan controller sequencer
// Accepts one event at a time, runs the divider when needed and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module fsc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  fsc_pkg::stat_t  stat_i,
  output fsc_pkg::cmd_t   cmd_o
);
  import fsc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Sequencing of one request.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat_i.need_div) begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIV;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule
